// ===== hw/rtl/btop_pkg.sv =====
// Package for the binomial tree option pricer: constants, types, helpers.
package btop_pkg;

  localparam int unsigned MaxStepsDef = 256;
  localparam int unsigned PriceW      = 48;
  localparam int unsigned FactorW     = 32;
  localparam int unsigned StepW       = 9;
  localparam int unsigned CfgAddrW    = 3;

  localparam logic [PriceW-1:0] PriceMax = {PriceW{1'b1}};
  localparam logic [PriceW-1:0] OneQ30   = PriceW'(64'h4000_0000);

  localparam logic [CfgAddrW-1:0] RegIsPut  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegStrike = 3'd1;
  localparam logic [CfgAddrW-1:0] RegSteps  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegUp     = 3'd3;
  localparam logic [CfgAddrW-1:0] RegDown   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegPUp    = 3'd5;
  localparam logic [CfgAddrW-1:0] RegPDown  = 3'd6;

  // shift selection for the shared multiply unit
  typedef enum logic [1:0] {
    MulSh30 = 2'd0,
    MulSh32 = 2'd1
  } mul_shift_e;

endpackage

// ===== hw/rtl/btop_mul.sv =====
// Pipelined 48x48 multiplier with right shift and 48-bit saturation.
module btop_mul
  import btop_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [PriceW-1:0] a_i,
  input  logic [PriceW-1:0] b_i,
  input  mul_shift_e        shift_i,
  output logic              valid_o,
  output logic [PriceW-1:0] res_o,
  output logic              sat_o
);

  // stage 1: four 24x24 partial products
  logic [47:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  mul_shift_e  sh1_q, sh2_q;
  logic        v1_q, v2_q, v3_q;
  logic [95:0] prod_q;
  logic [95:0] prod_d;
  logic [95:0] shifted;
  logic [PriceW-1:0] res_q;
  logic        sat_q;

  always_ff @(posedge clk_i) begin
    pp_ll_q <= a_i[23:0]  * b_i[23:0];
    pp_lh_q <= a_i[23:0]  * b_i[47:24];
    pp_hl_q <= a_i[47:24] * b_i[23:0];
    pp_hh_q <= a_i[47:24] * b_i[47:24];
    sh1_q   <= shift_i;
    sh2_q   <= sh1_q;
    prod_q  <= prod_d;
    res_q   <= shifted[PriceW-1:0];
    sat_q   <= (shifted[95:PriceW] != '0);
  end

  always_comb begin
    prod_d = {pp_hh_q, 48'd0} + {24'd0, pp_lh_q, 24'd0} + {24'd0, pp_hl_q, 24'd0}
           + {48'd0, pp_ll_q};
  end

  assign shifted = (sh2_q == MulSh32) ? (prod_q >> 32) : (prod_q >> 30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign sat_o   = sat_q;
  assign res_o   = sat_q ? PriceMax : res_q;

endmodule

// ===== hw/rtl/binomial_tree_option_price.sv =====
// Binomial tree option pricer, top level.
// Each multiply goes through a 3-stage multiplier and the sequencer waits for its result;
// only the backward pass issues its two weight multiplies back to back.
// Throughput: one item at a time; the output register frees the input side
// as soon as the result is captured. Reset clears control state and loads
// register defaults (call, K=0, N=1, u=d=1.0, p1=p2=0.5); memories are not cleared.
module binomial_tree_option_price
  import btop_pkg::*;
#(
  parameter int unsigned MAX_STEPS = MaxStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_index_i,
  input  logic [PriceW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PriceW-1:0]   spot_price_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PriceW-1:0]   option_value_o,
  output logic                overflow_o
);

  localparam int unsigned Depth = MAX_STEPS + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(MAX_STEPS + 1) + 1;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StPowA  = 9'b000000010,  // up/down power k: issue up multiply
    StPowB  = 9'b000000100,  // wait, issue down multiply
    StLeafR = 9'b000001000,  // read powers for leaf i
    StLeafA = 9'b000010000,  // multiply u^(n-i)*d^i, then S*fac
    StLeafB = 9'b000100000,
    StBackR = 9'b001000000,  // read V[i], V[i+1]
    StBackA = 9'b010000000,  // multiply both weights, add, write back
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic              is_put_q;
  logic [PriceW-1:0] strike_q;
  logic [StepW-1:0]  steps_q;
  logic [FactorW-1:0] up_q, down_q, pup_q, pdown_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_put_q <= 1'b0;
      strike_q <= '0;
      steps_q  <= StepW'(1);
      up_q     <= 32'h4000_0000;
      down_q   <= 32'h4000_0000;
      pup_q    <= 32'h8000_0000;
      pdown_q  <= 32'h8000_0000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegIsPut:  is_put_q <= cfg_data_i[0];
        RegStrike: strike_q <= cfg_data_i;
        RegSteps:  steps_q  <= cfg_data_i[StepW-1:0];
        RegUp:     up_q     <= cfg_data_i[FactorW-1:0];
        RegDown:   down_q   <= cfg_data_i[FactorW-1:0];
        RegPUp:    pup_q    <= cfg_data_i[FactorW-1:0];
        RegPDown:  pdown_q  <= cfg_data_i[FactorW-1:0];
        default: ;
      endcase
    end
  end

  // memories: powers hold {u^k, d^k} per entry, read at two addresses
  logic [2*PriceW-1:0] pow_mem [Depth];
  logic [PriceW-1:0]   node_mem [Depth];
  logic [PriceW-1:0]   up_rd_q, dn_rd_q, node_rd_q, node_rd2_q;

  logic                pow_we, node_we;
  logic [AddrW-1:0]    pow_wa, node_wa, up_ra, dn_ra, node_ra, node_ra2;
  logic [2*PriceW-1:0] pow_wd;
  logic [PriceW-1:0]   node_wd;

  always_ff @(posedge clk_i) begin
    if (pow_we) pow_mem[pow_wa] <= pow_wd;
    up_rd_q <= pow_mem[up_ra][2*PriceW-1:PriceW];
    dn_rd_q <= pow_mem[dn_ra][PriceW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd_q  <= node_mem[node_ra];
    node_rd2_q <= node_mem[node_ra2];
  end

  // datapath registers
  logic [CntW-1:0]   n_q, k_q, i_q;
  logic [CntW-1:0]   n_d, k_d, i_d;
  logic [PriceW-1:0] spot_q, acc_q, upp_q, dnp_q;
  logic [PriceW-1:0] spot_d, acc_d, upp_d, dnp_d;
  logic              ovf_q, ovf_d;
  logic [2:0]        ph_q, ph_d;
  logic              ov_valid_q, ov_valid_d;
  logic [PriceW-1:0] ov_val_q, ov_val_d;
  logic              ov_flag_q, ov_flag_d;

  // multiplier
  logic              m_valid, m_done, m_sat;
  logic [PriceW-1:0] m_a, m_b, m_res;
  mul_shift_e        m_sh;

  btop_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .a_i     (m_a),
    .b_i     (m_b),
    .shift_i (m_sh),
    .valid_o (m_done),
    .res_o   (m_res),
    .sat_o   (m_sat)
  );

  logic [PriceW-1:0] pay;
  logic [PriceW:0]   sum;

  always_comb begin
    if (is_put_q) pay = (strike_q > m_res) ? strike_q - m_res : '0;
    else          pay = (m_res > strike_q) ? m_res - strike_q : '0;
    sum = {1'b0, acc_q} + {1'b0, m_res};
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    n_d = n_q; k_d = k_q; i_d = i_q;
    spot_d = spot_q; acc_d = acc_q; upp_d = upp_q; dnp_d = dnp_q;
    ovf_d = ovf_q; ph_d = ph_q;
    ov_valid_d = ov_valid_q; ov_val_d = ov_val_q; ov_flag_d = ov_flag_q;
    m_valid = 1'b0; m_a = '0; m_b = '0; m_sh = MulSh30;
    pow_we = 1'b0; node_we = 1'b0;
    pow_wa = k_q[AddrW-1:0]; node_wa = i_q[AddrW-1:0];
    pow_wd = {upp_q, m_res}; node_wd = pay;
    up_ra = AddrW'(n_q - i_q); dn_ra = i_q[AddrW-1:0];
    node_ra = i_q[AddrW-1:0]; node_ra2 = AddrW'(i_q + CntW'(1));

    if (ov_valid_q && out_ready_i) ov_valid_d = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          spot_d = spot_price_i;
          n_d = (32'(steps_q) > MAX_STEPS) ? CntW'(MAX_STEPS) : CntW'(steps_q);
          ovf_d = 1'b0;
          pow_we = 1'b1;
          pow_wa = '0;
          pow_wd = {OneQ30, OneQ30};
          upp_d = OneQ30; dnp_d = OneQ30;
          k_d = CntW'(1); i_d = '0; ph_d = '0;
          state_d = (n_d == '0) ? StLeafR : StPowA;
        end
      end
      StPowA: begin
        if (ph_q == '0) begin
          m_valid = 1'b1; m_a = upp_q; m_b = PriceW'(up_q);
          ph_d = 3'd1;
        end else if (m_done) begin
          upp_d = m_res; ovf_d = ovf_q | m_sat;
          ph_d = '0; state_d = StPowB;
        end
      end
      StPowB: begin
        if (ph_q == '0) begin
          m_valid = 1'b1; m_a = dnp_q; m_b = PriceW'(down_q);
          ph_d = 3'd1;
        end else if (m_done) begin
          // write u^k (held in upp_q) and d^k together
          pow_we = 1'b1; dnp_d = m_res; ovf_d = ovf_q | m_sat;
          ph_d = '0;
          if (k_q == n_q) begin
            i_d = '0; state_d = StLeafR;
          end else begin
            k_d = k_q + CntW'(1); state_d = StPowA;
          end
        end
      end
      StLeafR: begin
        // address driven by default; data arrives next cycle
        ph_d = '0; state_d = StLeafA;
      end
      StLeafA: begin
        if (ph_q == '0) begin
          m_valid = 1'b1; m_a = up_rd_q; m_b = dn_rd_q;
          ph_d = 3'd1;
        end else if (m_done) begin
          ovf_d = ovf_q | m_sat; acc_d = m_res;
          ph_d = '0; state_d = StLeafB;
        end
      end
      StLeafB: begin
        if (ph_q == '0) begin
          m_valid = 1'b1; m_a = spot_q; m_b = acc_q;
          ph_d = 3'd1;
        end else if (m_done) begin
          ovf_d = ovf_q | m_sat;
          node_we = 1'b1;
          ph_d = '0;
          if (i_q == n_q) begin
            k_d = n_q; i_d = '0;
            state_d = (n_q == '0) ? StOut : StBackR;
          end else begin
            i_d = i_q + CntW'(1); state_d = StLeafR;
          end
        end
      end
      StBackR: begin
        ph_d = '0; state_d = StBackA;
      end
      StBackA: begin
        case (ph_q)
          3'd0: begin
            m_valid = 1'b1; m_a = PriceW'(pup_q); m_b = node_rd_q; m_sh = MulSh32;
            ph_d = 3'd1;
          end
          3'd1: begin
            m_valid = 1'b1; m_a = PriceW'(pdown_q); m_b = node_rd2_q; m_sh = MulSh32;
            ph_d = 3'd2;
          end
          3'd2: begin
            if (m_done) begin
              acc_d = m_res; ovf_d = ovf_q | m_sat; ph_d = 3'd3;
            end
          end
          default: begin
            ovf_d = ovf_q | m_sat | sum[PriceW];
            node_we = 1'b1;
            node_wd = sum[PriceW] ? PriceMax : sum[PriceW-1:0];
            ph_d = '0;
            if (i_q + CntW'(1) == k_q) begin
              i_d = '0; k_d = k_q - CntW'(1);
              state_d = (k_q == CntW'(1)) ? StOut : StBackR;
            end else begin
              i_d = i_q + CntW'(1); state_d = StBackR;
            end
          end
        endcase
      end
      StOut: begin
        node_ra = '0;
        if (ph_q == '0) begin
          ph_d = 3'd1;
        end else if (!ov_valid_q || out_ready_i) begin
          ov_valid_d = 1'b1; ov_val_d = node_rd_q; ov_flag_d = ovf_q;
          ph_d = '0; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ph_q <= '0;
      ov_valid_q <= 1'b0;
      n_q <= '0; k_q <= '0; i_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      ov_valid_q <= ov_valid_d;
      n_q <= n_d; k_q <= k_d; i_q <= i_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spot_q <= spot_d; acc_q <= acc_d; upp_q <= upp_d; dnp_q <= dnp_d;
    ov_val_q <= ov_val_d; ov_flag_q <= ov_flag_d;
  end

  assign out_valid_o    = ov_valid_q;
  assign option_value_o = ov_val_q;
  assign overflow_o     = ov_flag_q;

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBackA) |-> (i_q < k_q && k_q <= n_q))
    else $error("backward index out of range");
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MAX_STEPS))
    else $error("step count above maximum");
  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != StIdle))
    else $error("accepted item not started");

endmodule
